// File: rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// same, on the default clk / arst_n pair
`define ASSERT_STD(lbl, prop, msg) \
	`ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// File: rtl/rfmq_pkg.sv
package rfmq_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 4;
	localparam int CFG_W  = 5;

	localparam logic [CFG_W-1:0] RING_SIZE_RST = 5'd16;

	typedef enum logic [1:0] {
		CMD_ENQ  = 2'd0,
		CMD_DEQ  = 2'd1,
		CMD_PEEK = 2'd2,
		CMD_MAX  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

// File: rtl/rfmq_if.sv
interface rfmq_req_if;
	import rfmq_pkg::*;

	logic                     valid;
	logic                     ready;
	cmd_t                     cmd;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, cmd, value, input ready);
	modport sink   (input valid, cmd, value, output ready);
endinterface

interface rfmq_rsp_if;
	import rfmq_pkg::*;

	logic                     valid;
	logic                     ready;
	status_t                  status;
	logic signed [DATA_W-1:0] data;
	logic [CNT_W-1:0]         count;

	modport source (output valid, status, data, count, input ready);
	modport sink   (input valid, status, data, count, output ready);
endinterface

// File: rtl/rfmq_ram.sv
module rfmq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/ring_fifo_with_max_query.sv
// channel  dir  fields                handshake
// req      in   cmd[1:0] value[31:0]  valid/ready
// rsp      out  status[1:0] data[31:0] count[3:0]  valid/ready
// cfg      in   cfg_wdata[4:0]        cfg_we, no wait
//
// One command at a time; req.ready drops after a transfer until the result is loaded.
// Max scans every item held, one RAM read per cycle through the
// single read port and one signed compare.
// A pending unread result holds the sequencer before loading the next one.
// arst_n clears the read and write indices, state and valid; ring_size returns to 16.
module ring_fifo_with_max_query
	import rfmq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	rfmq_req_if.sink         req,
	rfmq_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int IW = $clog2(DEPTH);
	localparam int SW = ($clog2(DEPTH + 1) > CFG_W) ? $clog2(DEPTH + 1) : CFG_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DONE
	} state_t;

	state_t                   state_q;
	logic [CFG_W-1:0]         ring_size_q;
	logic [IW-1:0]            rd_q;
	logic [IW-1:0]            wr_q;
	logic [IW-1:0]            p_q;
	cmd_t                     cmd_q;
	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] best_q;
	logic                     first_q;
	status_t                  status_q;

	logic                     rsp_valid_q;
	status_t                  rsp_status_q;
	logic signed [DATA_W-1:0] rsp_data_q;
	logic [CNT_W-1:0]         rsp_count_q;

	logic [SW-1:0]            size_eff;
	logic [SW-1:0]            rs_ext;
	logic [SW-1:0]            held;
	logic                     empty;
	logic                     full;
	logic signed [DATA_W-1:0] rdata;
	logic signed [DATA_W-1:0] best_nxt;
	logic                     mem_we;
	logic                     mem_re;
	logic [IW-1:0]            mem_raddr;
	logic                     rsp_load;

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] p, input logic [SW-1:0] sz);
		logic [IW-1:0] r;
		if (SW'(p) + SW'(1) == sz) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	always_comb begin
		rs_ext = SW'(ring_size_q);
		if (rs_ext < SW'(2)) begin
			size_eff = SW'(2);
		end else if (rs_ext > SW'(DEPTH)) begin
			size_eff = SW'(DEPTH);
		end else begin
			size_eff = rs_ext;
		end
	end

	always_comb begin
		if (wr_q >= rd_q) begin
			held = SW'(wr_q) - SW'(rd_q);
		end else begin
			held = SW'(wr_q) + size_eff - SW'(rd_q);
		end
	end

	assign empty = (rd_q == wr_q);
	assign full  = (nxt(wr_q, size_eff) == rd_q);

	assign best_nxt = (first_q || (rdata > best_q)) ? rdata : best_q;

	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	assign mem_we    = (state_q == S_EXEC) && (cmd_q == CMD_ENQ) && !full;
	assign mem_re    = ((state_q == S_EXEC) && (cmd_q != CMD_ENQ) && !empty)
	                || ((state_q == S_SCAN) && (cmd_q == CMD_MAX) && (p_q != wr_q));
	assign mem_raddr = (state_q == S_EXEC) ? rd_q : p_q;

	rfmq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_q),
		.wdata (val_q),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ring_size_q <= RING_SIZE_RST;
			rd_q        <= '0;
			wr_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q   <= req.cmd;
						val_q   <= req.value;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					best_q <= '0;
					if (cmd_q == CMD_ENQ) begin
						state_q <= S_DONE;
						if (full) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_OK;
							wr_q     <= nxt(wr_q, size_eff);
						end
					end else if (empty) begin
						status_q <= ST_EMPTY;
						state_q  <= S_DONE;
					end else begin
						status_q <= ST_OK;
						p_q      <= nxt(rd_q, size_eff);
						first_q  <= 1'b1;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					first_q <= 1'b0;
					best_q  <= best_nxt;
					if (cmd_q == CMD_MAX) begin
						if (p_q != wr_q) begin
							p_q <= nxt(p_q, size_eff);
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						if (cmd_q == CMD_DEQ) begin
							rd_q <= nxt(rd_q, size_eff);
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_status_q <= status_q;
						rsp_data_q   <= best_q;
						rsp_count_q  <= held[CNT_W-1:0];
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// the user must write config only while idle; the block does not enforce it
			if (cfg_we) begin
				ring_size_q <= cfg_wdata;
				rd_q        <= '0;
				wr_q        <= '0;
			end
		end
	end

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.data   = rsp_data_q;
	assign rsp.count  = rsp_count_q;

endmodule

// File: rtl/rfmq_checker.sv
`include "assert_macros.svh"

module rfmq_checker
	import rfmq_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_ready,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input status_t                  rsp_status,
	input logic signed [DATA_W-1:0] rsp_data,
	input logic [CNT_W-1:0]         rsp_count
);

	`ASSERT_STD(a_busy_after_req, (req_valid && req_ready) |=> !req_ready, "ready after transfer")
	`ASSERT_STD(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)), "rsp dropped")
	`ASSERT_STD(a_empty_zero, (rsp_valid && (rsp_status == ST_EMPTY)) |-> ((rsp_data == 0) && (rsp_count == 0)), "empty result")
	`ASSERT_STD(a_full_zero, (rsp_valid && (rsp_status == ST_FULL)) |-> (rsp_data == 0), "full result data")

endmodule

bind ring_fifo_with_max_query rfmq_checker u_rfmq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_data   (rsp.data),
	.rsp_count  (rsp.count)
);
